FILE: design/csesc_pkg.sv
// Shared types, codes and escape tables for the C string escaper.
package csesc_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } csesc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } csesc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
  } csesc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic cur_last;
    logic op_valid;
  } csesc_sts_t;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic CFG_LINE_WIDTH = 1'b0;
  localparam logic CFG_KEEP_DQ    = 1'b1;

  localparam logic [5:0] LINE_WIDTH_MAX = 6'd58;
  localparam logic [5:0] TAB_SPACES     = 6'd4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // escape sequence kinds
  localparam logic [3:0] K_NONE  = 4'd0;
  localparam logic [3:0] K_START = 4'd1;
  localparam logic [3:0] K_QKEEP = 4'd2;
  localparam logic [3:0] K_QCONV = 4'd3;
  localparam logic [3:0] K_BSL   = 4'd4;
  localparam logic [3:0] K_NL    = 4'd5;
  localparam logic [3:0] K_TAB   = 4'd6;
  localparam logic [3:0] K_OCT   = 4'd7;
  localparam logic [3:0] K_PLAIN = 4'd8;
  localparam logic [3:0] K_END   = 4'd9;

  // bytes emitted after the space padding
  function automatic logic [2:0] tail_len(input logic [3:0] kind);
    logic [2:0] n;
    case (kind)
      K_START: n = 3'd3;
      K_QKEEP: n = 3'd2;
      K_QCONV: n = 3'd1;
      K_BSL:   n = 3'd2;
      K_NL:    n = 3'd4;
      K_OCT:   n = 3'd4;
      K_PLAIN: n = 3'd1;
      K_END:   n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [3:0] kind, input logic [2:0] idx,
                                           input logic [7:0] ch);
    logic [7:0] b;
    b = CH_BSL;
    case (kind)
      K_START: begin
        case (idx)
          3'd0:    b = CH_DQ;
          3'd1:    b = CH_BSL;
          default: b = CH_LF;
        endcase
      end
      K_QKEEP: b = (idx == 3'd0) ? CH_BSL : CH_DQ;
      K_QCONV: b = CH_SQ;
      K_BSL:   b = CH_BSL;
      K_NL, K_END: begin
        case (idx)
          3'd0:    b = CH_BSL;
          3'd1:    b = CH_N;
          3'd2:    b = CH_BSL;
          3'd3:    b = CH_LF;
          3'd4:    b = CH_DQ;
          3'd5:    b = CH_SEMI;
          default: b = CH_LF;
        endcase
      end
      K_OCT: begin
        case (idx)
          3'd0:    b = CH_BSL;
          3'd1:    b = CH_ZERO + {6'd0, ch[7:6]};
          3'd2:    b = CH_ZERO + {5'd0, ch[5:3]};
          default: b = CH_ZERO + {5'd0, ch[2:0]};
        endcase
      end
      K_PLAIN: b = ch;
      default: b = CH_BSL;
    endcase
    return b;
  endfunction

endpackage

FILE: design/c_string_escaper_with_padding_core.sv
// Top level of the C string literal escaper with line padding.
//
// Input channel in_valid/in_ready/in_data carries one item per transfer:
// start of text, a data byte or end of text. Each item expands into 1 to 64
// result bytes on out_valid/out_ready/out_data; out_data.last flags the final
// byte of an item. Operation code 3 is dropped without results.
// An accepted item is loaded into the sequencer registers, which step its
// results into the output register. Results leave at one byte per cycle
// while the receiver is ready; the next item is taken in the cycle the last
// byte of the current one is loaded into the output register, so plain
// bytes also stream at one per cycle. Padding spaces and escape sequences
// are likewise emitted by the single sequencer at one byte per cycle.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits; in_ready drops until the current item is finished.
// Reset (rst_n low, synchronous) clears the column count and output
// register and sets line width 58, keep_double_quote 0. The user must write
// config (cfg_we, cfg_index, cfg_wdata) only while idle; the block does not
// enforce it. Index 0: line width (saturated at 58); 1: keep_double_quote.
module c_string_escaper_with_padding_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csesc_pkg::csesc_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csesc_pkg::csesc_out_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [5:0]            cfg_wdata
);
  import csesc_pkg::*;

  csesc_cmd_t cmd;
  csesc_sts_t sts;

  csesc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csesc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a byte is only sequenced into a free output register
  a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> sts.out_free)
    else $error("step into occupied output register");

  // a new item overlaps only with the last byte of the previous one
  a_load_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && cmd.step) |-> sts.cur_last)
    else $error("item loaded before previous one finished");

  // after reset the block is ready for an item
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");

  // a sequenced byte shows up as valid output in the next cycle
  a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid)
    else $error("emitted byte missing at output");

endmodule

FILE: design/csesc_ctrl.sv
// Controller: idle/busy sequencing of item loads and result emission.
module csesc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csesc_pkg::csesc_sts_t sts,
  output csesc_pkg::csesc_cmd_t cmd
);
  import csesc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    cmd.step  = (state_r == ST_BUSY) && sts.out_free;
    // next item may enter in the cycle the last result of this one is emitted
    in_ready  = (state_r == ST_IDLE) || (cmd.step && sts.cur_last);
    cmd.load  = in_valid && in_ready;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load && sts.op_valid) state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (cmd.load)                        state_nxt = sts.op_valid ? ST_BUSY : ST_IDLE;
        else if (cmd.step && sts.cur_last)   state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/csesc_datapath.sv
// Datapath: config registers, column counter, escape sequencer and output register.
module csesc_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csesc_pkg::csesc_in_t  in_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [5:0]            cfg_wdata,
  input  csesc_pkg::csesc_cmd_t cmd,
  output csesc_pkg::csesc_sts_t sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csesc_pkg::csesc_out_t out_data
);
  import csesc_pkg::*;

  logic [5:0] line_width_r;
  logic       keep_dq_r;
  logic [7:0] col_r;
  logic [7:0] col_nxt;
  logic [7:0] col_inc;
  logic [3:0] kind_r;
  logic [3:0] kind_nxt;
  logic [5:0] pad_r;
  logic [5:0] pad_nxt;
  logic [2:0] idx_r;
  logic [7:0] ch_r;
  logic       out_valid_r;
  csesc_out_t out_data_r;

  logic [5:0] pad_nl;
  logic [5:0] pad_end;
  logic [8:0] end_lim;
  logic [2:0] cur_len;
  logic [7:0] cur_byte;
  logic       cur_last;

  // load-side decode
  always_comb begin
    col_inc = (col_r == 8'hFF) ? col_r : col_r + 8'd1;
    pad_nl  = ({2'd0, line_width_r} > col_inc) ? 6'({2'd0, line_width_r} - col_inc) : 6'd0;
    end_lim = {1'b0, col_r} + 9'd1;
    pad_end = ({3'd0, line_width_r} > end_lim) ? 6'({3'd0, line_width_r} - end_lim) : 6'd0;

    kind_nxt = K_NONE;
    col_nxt  = col_r;
    case (in_data.operation)
      OP_START: begin
        kind_nxt = K_START;
        col_nxt  = 8'd0;
      end
      OP_DATA: begin
        col_nxt = col_inc;
        if (in_data.data_byte == CH_DQ)
          kind_nxt = keep_dq_r ? K_QKEEP : K_QCONV;
        else if (in_data.data_byte == CH_BSL)
          kind_nxt = K_BSL;
        else if (in_data.data_byte == CH_CR || in_data.data_byte == CH_LF) begin
          kind_nxt = K_NL;
          col_nxt  = 8'd0;
        end else if (in_data.data_byte == CH_TAB)
          kind_nxt = K_TAB;
        else if (in_data.data_byte < CH_SPACE || in_data.data_byte == CH_DEL)
          kind_nxt = K_OCT;
        else
          kind_nxt = K_PLAIN;
      end
      OP_END: begin
        kind_nxt = K_END;
        col_nxt  = 8'd0;
      end
      default: kind_nxt = K_NONE;
    endcase

    case (kind_nxt)
      K_NL:    pad_nxt = pad_nl;
      K_END:   pad_nxt = pad_end;
      K_TAB:   pad_nxt = TAB_SPACES;
      default: pad_nxt = 6'd0;
    endcase
  end

  // emit-side: padding spaces first, then the fixed tail
  always_comb begin
    cur_len = tail_len(kind_r);
    if (pad_r != 6'd0) begin
      cur_byte = CH_SPACE;
      cur_last = (pad_r == 6'd1) && (cur_len == 3'd0);
    end else begin
      cur_byte = tail_byte(kind_r, idx_r, ch_r);
      cur_last = (idx_r == cur_len - 3'd1);
    end
    sts.out_free = !out_valid_r || out_ready;
    sts.cur_last = cur_last;
    sts.op_valid = (in_data.operation != OP_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_MAX;
      keep_dq_r    <= 1'b0;
      col_r        <= 8'd0;
      kind_r       <= K_NONE;
      pad_r        <= 6'd0;
      idx_r        <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_WIDTH: line_width_r <= (cfg_wdata > LINE_WIDTH_MAX) ? LINE_WIDTH_MAX
                                                                       : cfg_wdata;
          CFG_KEEP_DQ:    keep_dq_r    <= cfg_wdata[0];
          default:        keep_dq_r    <= keep_dq_r;
        endcase
      end

      if (cmd.load) begin
        col_r  <= col_nxt;
        kind_r <= kind_nxt;
        pad_r  <= pad_nxt;
        idx_r  <= 3'd0;
      end else if (cmd.step) begin
        if (pad_r != 6'd0) pad_r <= pad_r - 6'd1;
        else               idx_r <= idx_r + 3'd1;
      end

      if (cmd.step)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) ch_r <= in_data.data_byte;
    if (cmd.step) begin
      out_data_r.out_byte <= cur_byte;
      out_data_r.last     <= cur_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: verif/c_string_escaper_with_padding_core_tb.sv
// Self-checking testbench for the C string literal escaper core.
`timescale 1ns / 100ps

module c_string_escaper_with_padding_core_tb;
  import csesc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 8;

  // Expected escaped text, built from each accepted item; compared byte by byte.
  class escape_checker;
    logic [5:0]  line_width;
    logic        keep_dq;
    logic [7:0]  column;
    csesc_out_t  pending_bytes[$];
    int          errors;

    function new();
      line_width = LINE_WIDTH_MAX;
      keep_dq    = 1'b0;
      column     = 8'd0;
      errors     = 0;
    endfunction

    function void write_reg(logic idx, logic [5:0] value);
      if (idx == CFG_LINE_WIDTH) begin
        line_width = (value > LINE_WIDTH_MAX) ? LINE_WIDTH_MAX : value;
      end else begin
        keep_dq = value[0];
      end
    endfunction

    function void push_byte(logic [7:0] b);
      csesc_out_t r;
      r.out_byte = b;
      r.last     = 1'b0;
      pending_bytes.push_back(r);
    endfunction

    function void push_spaces(int n);
      for (int i = 0; i < n; i++) push_byte(CH_SPACE);
    endfunction

    function void push_continuation();
      push_byte(CH_BSL);
      push_byte(CH_N);
      push_byte(CH_BSL);
      push_byte(CH_LF);
    endfunction

    function void note_item(csesc_in_t item);
      int         first;
      logic [7:0] ch;
      csesc_out_t r;
      first = pending_bytes.size();
      ch    = item.data_byte;
      case (item.operation)
        OP_START: begin
          push_byte(CH_DQ);
          push_byte(CH_BSL);
          push_byte(CH_LF);
          column = 8'd0;
        end
        OP_DATA: begin
          if (column != 8'hFF) column = column + 8'd1;
          if (ch == CH_DQ) begin
            if (keep_dq) begin
              push_byte(CH_BSL);
              push_byte(CH_DQ);
            end else begin
              push_byte(CH_SQ);
            end
          end else if (ch == CH_BSL) begin
            push_byte(CH_BSL);
            push_byte(CH_BSL);
          end else if (ch == CH_CR || ch == CH_LF) begin
            push_spaces(int'(line_width) - int'(column));
            push_continuation();
            column = 8'd0;
          end else if (ch == CH_TAB) begin
            push_spaces(4);
          end else if (ch < 8'd32 || ch == CH_DEL) begin
            push_byte(CH_BSL);
            push_byte(CH_ZERO + {6'd0, ch[7:6]});
            push_byte(CH_ZERO + {5'd0, ch[5:3]});
            push_byte(CH_ZERO + {5'd0, ch[2:0]});
          end else begin
            push_byte(ch);
          end
        end
        OP_END: begin
          push_spaces(int'(line_width) - int'(column) - 1);
          push_continuation();
          push_byte(CH_DQ);
          push_byte(CH_SEMI);
          push_byte(CH_LF);
          column = 8'd0;
        end
        default: ;
      endcase
      if (pending_bytes.size() > first) begin
        r = pending_bytes.pop_back();
        r.last = 1'b1;
        pending_bytes.push_back(r);
      end
    endfunction

    function void check_byte(csesc_out_t got);
      csesc_out_t want;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: byte %02h last %0b", got.out_byte, got.last);
      end else begin
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     want.out_byte, want.last, got.out_byte, got.last);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  csesc_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  csesc_out_t out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [5:0] cfg_wdata = 6'd0;

  escape_checker sb = new();

  int   cycles = 0;
  int   send_idle_pct = 20;
  int   recv_idle_pct = 30;
  int   items_sent = 0;
  logic hold_start = 1'b0;
  int   hold_left = 0;

  c_string_escaper_with_padding_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_start) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_byte(out_data);
  end

  // Leaves in_valid high after the transfer; the caller either sends again or lowers it.
  task automatic send_item(logic [1:0] op, logic [7:0] b);
    csesc_in_t item;
    item.operation = op;
    item.data_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_item(item);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [5:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_char(bit allow_nl);
    int         r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 55)      c = 8'($urandom_range(32, 126));
    else if (r < 65) c = ($urandom_range(1) != 0) ? CH_DQ : CH_BSL;
    else if (r < 73) c = CH_TAB;
    else if (r < 83) c = ($urandom_range(1) != 0) ? CH_CR : CH_LF;
    else if (r < 90) c = ($urandom_range(9) == 0) ? CH_DEL : 8'($urandom_range(0, 31));
    else             c = 8'($urandom_range(128, 255));
    if (!allow_nl && (c == CH_CR || c == CH_LF)) c = 8'h41;
    return c;
  endfunction

  // One literal; now and then the start or the end is dropped.
  task automatic send_text(int n, bit allow_nl);
    if ($urandom_range(9) != 0) send_item(OP_START, 8'($urandom_range(255)));
    repeat (n) send_item(OP_DATA, rand_char(allow_nl));
    if ($urandom_range(9) != 0) send_item(OP_END, 8'($urandom_range(255)));
  endtask

  initial begin
    int ph;
    int target;
    bit pressured;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, every byte class, ignored op, data without start.
    send_item(OP_START, 8'hFF);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h1F);
    send_item(OP_DATA, CH_DEL);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, CH_SPACE);
    send_item(OP_DATA, CH_DQ);
    send_item(OP_DATA, CH_BSL);
    send_item(OP_DATA, CH_TAB);
    send_item(OP_DATA, 8'h7E);
    send_item(OP_DATA, CH_CR);
    send_item(OP_DATA, CH_LF);
    send_item(OP_NONE, 8'hFF);
    send_item(OP_END, 8'h00);
    send_item(OP_DATA, 8'h78);
    send_item(OP_END, 8'hAA);
    drain();
    // out of range line width saturates
    write_cfg(CFG_LINE_WIDTH, 6'd63);
    write_cfg(CFG_KEEP_DQ, 6'd1);
    send_item(OP_START, 8'h55);
    send_item(OP_DATA, CH_DQ);
    send_item(OP_END, 8'h00);
    drain();
    // zero line width: padding counts go negative
    write_cfg(CFG_LINE_WIDTH, 6'd0);
    send_item(OP_START, 8'h00);
    send_item(OP_DATA, 8'h61);
    send_item(OP_DATA, CH_LF);
    send_item(OP_END, 8'h00);

    pressured = 1'b0;
    for (ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct <= 68;
          write_cfg(CFG_LINE_WIDTH, 6'd0);
          write_cfg(CFG_KEEP_DQ, 6'd0);
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct <= 7;
          write_cfg(CFG_LINE_WIDTH, 6'($urandom_range(1, 57)));
          write_cfg(CFG_KEEP_DQ, 6'd1);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          write_cfg(CFG_LINE_WIDTH, LINE_WIDTH_MAX);
          write_cfg(CFG_KEEP_DQ, 6'($urandom_range(63)));
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        // receiver holds off while the rest of the phase is still being offered
        if (!pressured && ph == 0) begin
          in_valid <= 1'b0;
          hold_start <= 1'b1;
          @(posedge clk);
          hold_start <= 1'b0;
          pressured = 1'b1;
        end
        if ($urandom_range(99) < 8) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        else send_text($urandom_range(1, 14), 1'b1);
        if (ph == 1 && pressured && items_sent + 4 >= target) begin
          drain();
          pressured = 1'b0;
        end
      end
      if (ph == 2) begin
        // long line: the column count must saturate, not wrap
        send_item(OP_START, 8'h00);
        repeat (255) send_item(OP_DATA, rand_char(1'b0));
        send_item(OP_DATA, CH_LF);
      end
    end

    drain();
    if (sb.pending_bytes.size() != 0) begin
      sb.errors++;
      $display("%0d expected results never arrived", sb.pending_bytes.size());
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
